/* hw/rtl/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and codes for the shelf rectangle packer.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int unsigned CoordW = 13;

  // Request and result payloads
  typedef struct packed {
    logic [12:0] req_width;
    logic [12:0] req_height;
  } srp_req_t;

  typedef struct packed {
    logic [11:0] placed_x;
    logic [11:0] placed_y;
    logic [1:0]  place_status;
    logic [12:0] current_size;
  } srp_res_t;

  // Region geometry and shelf state, all but the width
  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] tall;
    logic [CoordW-1:0] fill;
    logic [CoordW-1:0] shelf_start;
    logic [CoordW-1:0] shelf_end;
  } srp_geo_t;

  typedef enum logic [1:0] {
    STAT_PLACED = 2'd0,
    STAT_NO_FIT = 2'd1,
    STAT_FULL   = 2'd2
  } srp_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIT_RD,
    ST_FIT_CHK,
    ST_CNT_RD,
    ST_CNT_CHK,
    ST_GRW_RD,
    ST_GRW_CHK,
    ST_STRIP,
    ST_CMT_RD,
    ST_CMT_WR,
    ST_RST_RD,
    ST_RST_WR,
    ST_DONE
  } srp_state_e;

endpackage

/* hw/rtl/shelf_rectangle_packer_core.sv */
// ----------------------------------------------------------------------------
// shelf_rectangle_packer_core
// Places rectangles in a square atlas by first-fit over a region table,
// doubling the atlas when nothing fits.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_ready_o   srp_req_t  (width, height)
//  out      output     out_valid_o / out_ready_i srp_res_t  (x, y, status, size)
//
//  One request at a time. A search reads the regions one by one; each
//  growth step counts the regions, widens or extends them and adds the
//  bottom strip, and a request that grew then commits or rolls back the
//  widths before the result. The region memories share a single read
//  address. No clearing pass after reset. A result waiting
//  on out_ready_i does not stop the next request being taken.
module shelf_rectangle_packer_core #(
  parameter int unsigned START_SIZE  = 256,
  parameter int unsigned LIMIT_SIZE  = 4096,
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srp_pkg::srp_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output srp_pkg::srp_res_t out_data_o
);
  import srp_pkg::*;

  localparam int unsigned IW = $clog2(MAX_REGIONS);
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam logic [CoordW-1:0] StartSz = CoordW'(START_SIZE);
  localparam logic [CoordW:0]   LimitSz = (CoordW+1)'(LIMIT_SIZE);
  localparam logic [CW:0]       MaxReg  = (CW+1)'(MAX_REGIONS);

  // Region memories: geometry, working width and committed width
  srp_geo_t          mem_geo  [MAX_REGIONS];
  logic [CoordW-1:0] mem_wide [MAX_REGIONS];
  logic [CoordW-1:0] mem_bak  [MAX_REGIONS];

  srp_state_e        state_q, state_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     count_q, count_d, cnt_sav_q, cnt_sav_d, n_q, n_d;
  logic [CW:0]       adds_q, adds_d;
  logic [CoordW-1:0] side_q, side_d, side_sav_q, side_sav_d;
  logic [CoordW-1:0] bw_q, bw_d, bh_q, bh_d;
  logic              grew_q, grew_d;
  logic              geo0_ok_q, wide0_ok_q, bak0_ok_q;
  logic              out_valid_q, out_valid_d;
  srp_res_t          res_q, res_d, out_q, out_d;

  logic [IW-1:0]     rd_addr;
  srp_geo_t          geo_rdq, geo_rd, geo_wdata;
  logic [CoordW-1:0] wide_rdq, wide_rd, bak_rdq, bak_rd, wide_wdata, bak_wdata;
  logic              geo_dflt_q, wide_dflt_q, bak_dflt_q;
  logic              geo_we, wide_we, bak_we;
  logic [IW-1:0]     geo_waddr, wide_waddr, bak_waddr;

  // Memory ports, read data registered
  always_ff @(posedge clk_i) begin
    geo_rdq  <= mem_geo[rd_addr];
    wide_rdq <= mem_wide[rd_addr];
    bak_rdq  <= mem_bak[rd_addr];
    if (geo_we)  mem_geo[geo_waddr]   <= geo_wdata;
    if (wide_we) mem_wide[wide_waddr] <= wide_wdata;
    if (bak_we)  mem_bak[bak_waddr]   <= bak_wdata;
  end

  // Entry 0 reads as the start region until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geo0_ok_q   <= 1'b0;
      wide0_ok_q  <= 1'b0;
      bak0_ok_q   <= 1'b0;
      geo_dflt_q  <= 1'b0;
      wide_dflt_q <= 1'b0;
      bak_dflt_q  <= 1'b0;
    end else begin
      if (geo_we && geo_waddr == '0)   geo0_ok_q  <= 1'b1;
      if (wide_we && wide_waddr == '0) wide0_ok_q <= 1'b1;
      if (bak_we && bak_waddr == '0)   bak0_ok_q  <= 1'b1;
      geo_dflt_q  <= (rd_addr == '0) && !geo0_ok_q;
      wide_dflt_q <= (rd_addr == '0) && !wide0_ok_q;
      bak_dflt_q  <= (rd_addr == '0) && !bak0_ok_q;
    end
  end

  always_comb begin
    geo_rd      = geo_rdq;
    if (geo_dflt_q) begin
      geo_rd      = '0;
      geo_rd.tall = StartSz;
    end
    wide_rd = wide_dflt_q ? StartSz : wide_rdq;
    bak_rd  = bak_dflt_q ? StartSz : bak_rdq;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      count_q     <= CW'(1);
      cnt_sav_q   <= CW'(1);
      n_q         <= '0;
      adds_q      <= '0;
      side_q      <= StartSz;
      side_sav_q  <= StartSz;
      grew_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      cnt_sav_q   <= cnt_sav_d;
      n_q         <= n_d;
      adds_q      <= adds_d;
      side_q      <= side_d;
      side_sav_q  <= side_sav_d;
      grew_q      <= grew_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bw_q  <= bw_d;
    bh_q  <= bh_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // Fit test on the fetched region
  logic [CoordW:0] w_x, h_y, h_z, z_y, bw_x, bh_x;
  logic            too_small, new_shelf, fits, reach;
  srp_geo_t        geo_fit;
  logic [CoordW-1:0] px, py;

  always_comb begin
    bw_x      = {1'b0, bw_q};
    bh_x      = {1'b0, bh_q};
    w_x       = {1'b0, wide_rd} - {1'b0, geo_rd.fill};
    h_y       = {1'b0, geo_rd.tall} - {1'b0, geo_rd.shelf_start};
    h_z       = {1'b0, geo_rd.tall} - {1'b0, geo_rd.shelf_end};
    z_y       = {1'b0, geo_rd.shelf_end} - {1'b0, geo_rd.shelf_start};
    too_small = ({1'b0, wide_rd} < bw_x) || (h_y < bh_x);
    new_shelf = w_x < bw_x;
    fits      = !too_small && !(new_shelf && (h_z < bh_x));
    geo_fit   = geo_rd;
    if (new_shelf) begin
      geo_fit.shelf_start = geo_rd.shelf_end;
      geo_fit.shelf_end   = geo_rd.shelf_end + bh_q;
      geo_fit.fill        = bw_q;
      px                  = geo_rd.left;
      py                  = geo_rd.top + geo_rd.shelf_end;
    end else begin
      if (z_y < bh_x) geo_fit.shelf_end = geo_rd.shelf_start + bh_q;
      geo_fit.fill = geo_rd.fill + bw_q;
      px           = geo_rd.left + geo_rd.fill;
      py           = geo_rd.top + geo_rd.shelf_start;
    end
    reach = ({1'b0, geo_rd.left} + {1'b0, wide_rd}) >= {1'b0, side_q};
  end

  // Sequencer
  always_comb begin
    logic          last;
    logic [CW:0]   adds_nx;
    srp_geo_t      geo_new;
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    cnt_sav_d   = cnt_sav_q;
    n_d         = n_q;
    adds_d      = adds_q;
    side_d      = side_q;
    side_sav_d  = side_sav_q;
    grew_d      = grew_q;
    bw_d        = bw_q;
    bh_d        = bh_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    rd_addr     = idx_q[IW-1:0];
    geo_we      = 1'b0;
    geo_waddr   = idx_q[IW-1:0];
    geo_wdata   = geo_fit;
    wide_we     = 1'b0;
    wide_waddr  = idx_q[IW-1:0];
    wide_wdata  = wide_rd;
    bak_we      = 1'b0;
    bak_waddr   = idx_q[IW-1:0];
    bak_wdata   = wide_rd;
    last        = (idx_q + CW'(1)) == count_q;
    adds_nx     = adds_q;
    geo_new     = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          bw_d       = in_data_i.req_width;
          bh_d       = in_data_i.req_height;
          cnt_sav_d  = count_q;
          side_sav_d = side_q;
          grew_d     = 1'b0;
          idx_d      = '0;
          if (in_data_i.req_width == '0 || in_data_i.req_height == '0) begin
            res_d   = '{placed_x: '0, placed_y: '0, place_status: STAT_NO_FIT,
                        current_size: side_q};
            state_d = ST_DONE;
          end else begin
            state_d = ST_FIT_RD;
          end
        end
      end
      ST_FIT_RD: state_d = ST_FIT_CHK;
      ST_FIT_CHK: begin
        if (fits) begin
          geo_we = 1'b1;
          res_d  = '{placed_x: px[11:0], placed_y: py[11:0],
                     place_status: STAT_PLACED, current_size: side_q};
          idx_d  = '0;
          state_d = grew_q ? ST_CMT_RD : ST_DONE;
        end else if (!last) begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_FIT_RD;
        end else if ({side_q, 1'b0} > LimitSz) begin
          res_d = '{placed_x: '0, placed_y: '0, place_status: STAT_NO_FIT,
                    current_size: side_sav_q};
          count_d = cnt_sav_q;
          side_d  = side_sav_q;
          idx_d   = '0;
          state_d = grew_q ? ST_RST_RD : ST_DONE;
        end else begin
          idx_d   = '0;
          adds_d  = (CW+1)'(1);
          state_d = ST_CNT_RD;
        end
      end
      // Count the regions that growth must append
      ST_CNT_RD: state_d = ST_CNT_CHK;
      ST_CNT_CHK: begin
        if (reach && geo_rd.shelf_start != '0) adds_nx = adds_q + (CW+1)'(1);
        adds_d = adds_nx;
        if (!last) begin
          idx_d   = idx_q + CW'(1);
          state_d = ST_CNT_RD;
        end else if (({1'b0, count_q} + adds_nx) > MaxReg) begin
          res_d = '{placed_x: '0, placed_y: '0, place_status: STAT_FULL,
                    current_size: side_sav_q};
          count_d = cnt_sav_q;
          side_d  = side_sav_q;
          idx_d   = '0;
          state_d = grew_q ? ST_RST_RD : ST_DONE;
        end else begin
          idx_d   = '0;
          n_d     = count_q;
          state_d = ST_GRW_RD;
        end
      end
      // Widen or extend the regions on the right edge
      ST_GRW_RD: state_d = ST_GRW_CHK;
      ST_GRW_CHK: begin
        if (reach) begin
          wide_we = 1'b1;
          if (geo_rd.shelf_start == '0) begin
            wide_wdata = wide_rd + side_q;
          end else begin
            geo_new.left = side_q;
            geo_new.top  = geo_rd.top;
            geo_new.tall = geo_rd.tall;
            geo_we       = 1'b1;
            geo_waddr    = count_q[IW-1:0];
            geo_wdata    = geo_new;
            wide_waddr   = count_q[IW-1:0];
            wide_wdata   = side_q;
            count_d      = count_q + CW'(1);
          end
        end
        idx_d   = idx_q + CW'(1);
        state_d = ((idx_q + CW'(1)) == n_q) ? ST_STRIP : ST_GRW_RD;
      end
      // Bottom strip and the new side
      ST_STRIP: begin
        geo_new.top  = side_q;
        geo_new.tall = side_q;
        geo_we       = 1'b1;
        geo_waddr    = count_q[IW-1:0];
        geo_wdata    = geo_new;
        wide_we      = 1'b1;
        wide_waddr   = count_q[IW-1:0];
        wide_wdata   = {side_q[CoordW-2:0], 1'b0};
        count_d      = count_q + CW'(1);
        side_d       = {side_q[CoordW-2:0], 1'b0};
        grew_d       = 1'b1;
        idx_d        = '0;
        state_d      = ST_FIT_RD;
      end
      // Success after growth: commit widths
      ST_CMT_RD: state_d = ST_CMT_WR;
      ST_CMT_WR: begin
        bak_we = 1'b1;
        idx_d  = idx_q + CW'(1);
        state_d = last ? ST_DONE : ST_CMT_RD;
      end
      // Failure after growth: roll widths back
      ST_RST_RD: state_d = ST_RST_WR;
      ST_RST_WR: begin
        wide_we    = 1'b1;
        wide_wdata = bak_rd;
        idx_d      = idx_q + CW'(1);
        state_d    = last ? ST_DONE : ST_RST_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/srp_checker.sv */
// ----------------------------------------------------------------------------
// srp_checker
// Port-level checks for the shelf rectangle packer, bound to the top level.
// ----------------------------------------------------------------------------
module srp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input srp_pkg::srp_req_t in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input srp_pkg::srp_res_t out_data_o
);
  import srp_pkg::*;

  // A held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Only one request in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken during search");

  // Status code is one of the three defined
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.place_status != 2'd3)
    else $error("undefined status");

  // Failures report the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.place_status != STAT_PLACED |->
      out_data_o.placed_x == '0 && out_data_o.placed_y == '0)
    else $error("failure with nonzero position");

endmodule

bind shelf_rectangle_packer_core srp_checker u_srp_checker (.*);
